// ===== hdl/lpkf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpkf_pkg - shared definitions of the low-pass predicted Kalman filter
// Widths, register indexes, fixed-point constants and the small helper
// functions used by the filter datapath and its gain divider.
// ----------------------------------------------------------------------------
package lpkf_pkg;

   // Sample-domain values (samples, estimates, low-pass values), Q16.16.
   localparam int SAMPLE_W   = 32;
   // Coefficients Q2.30, noise terms Q0.32, covariance unsigned Q2.30.
   localparam int COEF_W     = 32;
   localparam int COV_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Gain is unsigned Q2.30 and never exceeds 1.0, so 31 bits hold it.
   localparam int GAIN_W  = 31;
   // Denominator 4C + R.
   localparam int DEN_W   = COV_W + 3;
   // Shared multiplier operands and product.
   localparam int MUL_W   = 32;
   localparam int PROD_W  = 2 * MUL_W;
   // A product rounded down by 30 bits.
   localparam int TERM_W  = PROD_W - 30;
   // Low-pass accumulator and correction magnitude.
   localparam int ACC_W   = 36;
   // Widest sample-domain sum before saturation.
   localparam int WIDE_W  = 37;
   // Step (lp - lp1) and innovation (x - est - step).
   localparam int STEP_W  = SAMPLE_W + 1;
   localparam int INNOV_W = SAMPLE_W + 3;

   localparam logic [COV_W-1:0]  COV_ONE  = COV_W'(32'h4000_0000);
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(32'h4000_0000);
   localparam logic [PROD_W-1:0] HALF_Q30 = PROD_W'(64'h2000_0000);

   localparam logic [COEF_W-1:0] COEF_INPUT_RST = COEF_W'(32'h4000_0000);
   localparam logic [COEF_W-1:0] NOISE_MEAS_RST = COEF_W'(32'd47244640);
   localparam logic [COEF_W-1:0] NOISE_PROC_RST = COEF_W'(32'd42950);

   localparam logic signed [WIDE_W-1:0] SAT_HI =
      {{(WIDE_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] SAT_LO =
      {{(WIDE_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_INPUT       = 3'd0,
      CSR_COEF_PREV        = 3'd1,
      CSR_COEF_PREV2       = 3'd2,
      CSR_NOISE_MEAS       = 3'd3,
      CSR_NOISE_PROC       = 3'd4,
      CSR_INITIAL_ESTIMATE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic ready;
   } div_status_type;

   // Clamp a wide signed sum to the signed sample range.
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] r;
      begin
         r = v;
         if (v > SAT_HI) r = SAT_HI;
         if (v < SAT_LO) r = SAT_LO;
         return r[SAMPLE_W-1:0];
      end
   endfunction

   // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
   function automatic logic [MUL_W-1:0] abs_val(input logic signed [MUL_W-1:0] v);
      begin
         return v[MUL_W-1] ? (~v + 1'b1) : v;
      end
   endfunction

   // Drop 30 fraction bits from a product magnitude, rounding half up.
   function automatic logic [TERM_W-1:0] round_q30(input logic [PROD_W-1:0] p);
      logic [PROD_W-1:0] s;
      begin
         s = p + HALF_Q30;
         return s[PROD_W-1:30];
      end
   endfunction

endpackage

// ===== hdl/lpkf_mul.sv =====
// ----------------------------------------------------------------------------
// lpkf_mul - shared unsigned multiplier
// One 32 by 32 bit unsigned product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module lpkf_mul (
   input  logic                            clock,
   input  logic [lpkf_pkg::MUL_W-1:0]      op_a,
   input  logic [lpkf_pkg::MUL_W-1:0]      op_b,
   output logic [lpkf_pkg::PROD_W-1:0]     prod
);

   logic [lpkf_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= lpkf_pkg::PROD_W'(op_a) * lpkf_pkg::PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/lpkf_div.sv =====
// ----------------------------------------------------------------------------
// lpkf_div - iterative Kalman gain divider
// Restoring division giving floor(C * 2^32 / (4C + R)), one quotient bit
// per cycle. A zero denominator yields a gain of zero.
// ----------------------------------------------------------------------------
module lpkf_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lpkf_pkg::COV_W-1:0]        cov,
   input  logic [lpkf_pkg::COEF_W-1:0]       noise,
   output lpkf_pkg::div_status_type          status,
   output logic [lpkf_pkg::GAIN_W-1:0]       gain
);

   localparam int CNT_W = $clog2(lpkf_pkg::GAIN_W);

   logic [lpkf_pkg::DEN_W-1:0]  den_ff;
   logic [lpkf_pkg::DEN_W-1:0]  rem_ff;
   logic [lpkf_pkg::GAIN_W-1:0] quo_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        zero_ff;
   logic                        busy_ff;
   logic                        ready_ff;

   logic [lpkf_pkg::DEN_W-1:0]  den_in;
   logic [lpkf_pkg::DEN_W:0]    shifted;
   logic                        fits;
   logic [lpkf_pkg::DEN_W:0]    diff;
   logic [lpkf_pkg::DEN_W-1:0]  rem_in;

   always_comb begin
      den_in  = {1'b0, cov, 2'b00} + {3'b000, noise};
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
      rem_in  = fits ? diff[lpkf_pkg::DEN_W-1:0] : shifted[lpkf_pkg::DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         ready_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (start) begin
         // The partial remainder starts at 2C, which is below the divisor
         // whenever the divisor is nonzero, so 31 steps cover the quotient.
         den_ff   <= den_in;
         rem_ff   <= {2'b00, cov, 1'b0};
         quo_ff   <= '0;
         zero_ff  <= den_in == '0;
         cnt_ff   <= CNT_W'(lpkf_pkg::GAIN_W - 1);
         busy_ff  <= 1'b1;
         ready_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[lpkf_pkg::GAIN_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_ff  <= 1'b0;
            ready_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   assign status.busy  = busy_ff;
   assign status.ready = ready_ff;
   assign gain         = zero_ff ? '0 : quo_ff;

endmodule

// ===== hdl/lowpass_predicted_kalman_filter_unit.sv =====
// ----------------------------------------------------------------------------
// lowpass_predicted_kalman_filter_unit - scalar Kalman filter with low-pass
// prediction
// Second-order low-pass recursion feeding the predicted step of a scalar
// Kalman filter, built around one shared multiplier and a gain divider.
// ----------------------------------------------------------------------------
// Each accepted sample beat produces exactly one result beat carrying the new
// Kalman estimate and the new low-pass value. The gain divider works out one
// quotient bit per cycle and sets the pace; the low-pass terms are multiplied
// while it runs, and after it finishes, three products on the shared 32 by 32
// multiplier finish the correction and the covariance update, the new state is
// committed, and the next sample can be taken in the cycle after the commit.
// While a sample is being worked on, req_stall is high. A finished result is
// held in an output register, so the next sample is accepted even while
// rsp_stall holds the previous result back; the block only waits at its
// commit step if the earlier result is still there. Configuration registers
// are written through csr_write, csr_index and csr_data and must be written
// only while the block is idle. Writing the initial estimate register reloads
// the estimate and sets the covariance back to 1.0. Unknown register indexes
// are ignored.
// ----------------------------------------------------------------------------
module lowpass_predicted_kalman_filter_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [lpkf_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lpkf_pkg::SAMPLE_W-1:0]   rsp_estimate,
   output logic signed [lpkf_pkg::SAMPLE_W-1:0]   rsp_lowpass_value,
   input  logic                                   csr_write,
   input  logic [lpkf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lpkf_pkg::CSR_DATA_W-1:0]        csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_IN,
      ST_MUL_PREV,
      ST_MUL_PREV2,
      ST_ACC_PREV2,
      ST_LP_SAT,
      ST_STEP,
      ST_INNOV,
      ST_GAIN_WAIT,
      ST_MUL_INNOV_LO,
      ST_MUL_INNOV_HI,
      ST_CORR,
      ST_EST,
      ST_COMMIT
   } state_type;

   localparam int SW = lpkf_pkg::SAMPLE_W;

   state_type state_ff;

   // Configuration registers.
   logic signed [lpkf_pkg::COEF_W-1:0] coef_input_ff;
   logic signed [lpkf_pkg::COEF_W-1:0] coef_prev_ff;
   logic signed [lpkf_pkg::COEF_W-1:0] coef_prev2_ff;
   logic [lpkf_pkg::COEF_W-1:0]        noise_meas_ff;
   logic [lpkf_pkg::COEF_W-1:0]        noise_proc_ff;

   // Filter state.
   logic signed [SW-1:0]               lp1_ff;
   logic signed [SW-1:0]               lp2_ff;
   logic signed [SW-1:0]               est_ff;
   logic [lpkf_pkg::COV_W-1:0]         cov_ff;

   // Working registers of one sample.
   logic signed [SW-1:0]               x_ff;
   logic                               neg_ff;
   logic signed [lpkf_pkg::ACC_W-1:0]  acc_ff;
   logic signed [SW-1:0]               lp_ff;
   logic signed [lpkf_pkg::STEP_W-1:0] step_ff;
   logic signed [lpkf_pkg::INNOV_W-1:0] innov_ff;
   logic [lpkf_pkg::TERM_W-1:0]        rl_ff;
   logic [lpkf_pkg::ACC_W-1:0]         corr_ff;
   logic signed [SW-1:0]               est_new_ff;
   logic [lpkf_pkg::COV_W:0]           cov_rnd_ff;

   // Result register.
   logic                               rsp_valid_ff;
   logic signed [SW-1:0]               rsp_estimate_ff;
   logic signed [SW-1:0]               rsp_lowpass_ff;

   // Shared units.
   logic [lpkf_pkg::MUL_W-1:0]         mul_a;
   logic [lpkf_pkg::MUL_W-1:0]         mul_b;
   logic                               mul_neg;
   logic [lpkf_pkg::PROD_W-1:0]        prod;
   lpkf_pkg::div_status_type           div_status;
   logic [lpkf_pkg::GAIN_W-1:0]        gain;
   logic                               div_start;

   logic                               req_accept;
   logic                               slot_free;
   logic [lpkf_pkg::TERM_W-1:0]        term;
   logic [lpkf_pkg::ACC_W-1:0]         term_ext;
   logic signed [lpkf_pkg::ACC_W-1:0]  term_signed;
   logic [lpkf_pkg::INNOV_W-1:0]       innov_abs;
   logic signed [lpkf_pkg::WIDE_W-1:0] corr_signed;
   logic signed [lpkf_pkg::WIDE_W-1:0] est_sum;
   logic [lpkf_pkg::COEF_W:0]          noise_proc_rnd;
   logic [lpkf_pkg::COV_W+1:0]         cov_sum;
   logic [lpkf_pkg::COV_W-1:0]         cov_next;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = state_ff != ST_IDLE;
   assign div_start  = req_accept;
   // The result register can take a new result when it is empty or its
   // current beat leaves in this cycle.
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   lpkf_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   lpkf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .cov    (cov_ff),
      .noise  (noise_meas_ff),
      .status (div_status),
      .gain   (gain)
   );

   // Operand selection for the shared multiplier. Products with a signed
   // factor are formed on magnitudes, and the sign is applied after the
   // rounding so that ties round away from zero. The term weighted by
   // coef_prev2 is subtracted, so its sign is flipped here.
   always_comb begin
      innov_abs = innov_ff[lpkf_pkg::INNOV_W-1] ? (~innov_ff + 1'b1) : innov_ff;
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      unique case (state_ff)
         ST_MUL_IN: begin
            mul_a   = lpkf_pkg::abs_val(x_ff);
            mul_b   = lpkf_pkg::abs_val(coef_input_ff);
            mul_neg = x_ff[SW-1] ^ coef_input_ff[lpkf_pkg::COEF_W-1];
         end
         ST_MUL_PREV: begin
            mul_a   = lpkf_pkg::abs_val(lp1_ff);
            mul_b   = lpkf_pkg::abs_val(coef_prev_ff);
            mul_neg = lp1_ff[SW-1] ^ coef_prev_ff[lpkf_pkg::COEF_W-1];
         end
         ST_MUL_PREV2: begin
            mul_a   = lpkf_pkg::abs_val(lp2_ff);
            mul_b   = lpkf_pkg::abs_val(coef_prev2_ff);
            mul_neg = !(lp2_ff[SW-1] ^ coef_prev2_ff[lpkf_pkg::COEF_W-1]);
         end
         ST_MUL_INNOV_LO: begin
            mul_a = innov_abs[lpkf_pkg::MUL_W-1:0];
            mul_b = {1'b0, gain};
         end
         ST_MUL_INNOV_HI: begin
            mul_a = lpkf_pkg::MUL_W'(innov_abs[lpkf_pkg::INNOV_W-2:lpkf_pkg::MUL_W]);
            mul_b = {1'b0, gain};
         end
         ST_CORR: begin
            mul_a = {1'b0, lpkf_pkg::GAIN_ONE - gain};
            mul_b = cov_ff;
         end
         ST_IDLE, ST_ACC_PREV2, ST_LP_SAT, ST_STEP, ST_INNOV, ST_GAIN_WAIT,
         ST_EST, ST_COMMIT: begin
            mul_a   = '0;
            mul_b   = '0;
            mul_neg = 1'b0;
         end
      endcase
   end

   always_comb begin
      term        = lpkf_pkg::round_q30(prod);
      term_ext    = {{(lpkf_pkg::ACC_W-lpkf_pkg::TERM_W){1'b0}}, term};
      term_signed = neg_ff ? (~term_ext + 1'b1) : term_ext;

      corr_signed = innov_ff[lpkf_pkg::INNOV_W-1] ? ~{1'b0, corr_ff} + 1'b1
                                                  : {1'b0, corr_ff};
      est_sum     = {{(lpkf_pkg::WIDE_W-SW){est_ff[SW-1]}}, est_ff}
                  + {{(lpkf_pkg::WIDE_W-lpkf_pkg::STEP_W){step_ff[lpkf_pkg::STEP_W-1]}},
                     step_ff}
                  + corr_signed;

      // Q is rounded from Q0.32 to Q2.30 before it is added.
      noise_proc_rnd = {1'b0, noise_proc_ff} + (lpkf_pkg::COEF_W+1)'(2);
      cov_sum  = {1'b0, cov_rnd_ff}
               + {3'b000, noise_proc_rnd[lpkf_pkg::COEF_W:2]};
      cov_next = (cov_sum[lpkf_pkg::COV_W+1:lpkf_pkg::COV_W] != 2'b00)
               ? '1 : cov_sum[lpkf_pkg::COV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         coef_input_ff <= lpkf_pkg::COEF_INPUT_RST;
         coef_prev_ff  <= '0;
         coef_prev2_ff <= '0;
         noise_meas_ff <= lpkf_pkg::NOISE_MEAS_RST;
         noise_proc_ff <= lpkf_pkg::NOISE_PROC_RST;
         lp1_ff        <= '0;
         lp2_ff        <= '0;
         est_ff        <= '0;
         cov_ff        <= lpkf_pkg::COV_ONE;
      end else begin
         neg_ff <= mul_neg;

         if (csr_write) begin
            unique case (lpkf_pkg::csr_index_type'(csr_index))
               lpkf_pkg::CSR_COEF_INPUT:  coef_input_ff <= csr_data;
               lpkf_pkg::CSR_COEF_PREV:   coef_prev_ff  <= csr_data;
               lpkf_pkg::CSR_COEF_PREV2:  coef_prev2_ff <= csr_data;
               lpkf_pkg::CSR_NOISE_MEAS:  noise_meas_ff <= csr_data;
               lpkf_pkg::CSR_NOISE_PROC:  noise_proc_ff <= csr_data;
               lpkf_pkg::CSR_INITIAL_ESTIMATE: begin
                  est_ff <= lpkf_pkg::sat_sample(
                     {{(lpkf_pkg::WIDE_W-lpkf_pkg::CSR_DATA_W){csr_data[
                        lpkf_pkg::CSR_DATA_W-1]}}, csr_data});
                  cov_ff <= lpkf_pkg::COV_ONE;
               end
               default: ;
            endcase
         end

         // A commit in the same cycle refills the register itself.
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_COMMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  x_ff     <= req_sample;
                  state_ff <= ST_MUL_IN;
               end
            end
            ST_MUL_IN: begin
               state_ff <= ST_MUL_PREV;
            end
            ST_MUL_PREV: begin
               acc_ff   <= term_signed;
               state_ff <= ST_MUL_PREV2;
            end
            ST_MUL_PREV2: begin
               acc_ff   <= acc_ff + term_signed;
               state_ff <= ST_ACC_PREV2;
            end
            ST_ACC_PREV2: begin
               acc_ff   <= acc_ff + term_signed;
               state_ff <= ST_LP_SAT;
            end
            ST_LP_SAT: begin
               lp_ff    <= lpkf_pkg::sat_sample(
                  {acc_ff[lpkf_pkg::ACC_W-1], acc_ff});
               state_ff <= ST_STEP;
            end
            ST_STEP: begin
               step_ff  <= {lp_ff[SW-1], lp_ff} - {lp1_ff[SW-1], lp1_ff};
               state_ff <= ST_INNOV;
            end
            ST_INNOV: begin
               // Step and innovation are kept exact, without saturation.
               innov_ff <= {{(lpkf_pkg::INNOV_W-SW){x_ff[SW-1]}}, x_ff}
                         - {{(lpkf_pkg::INNOV_W-SW){est_ff[SW-1]}}, est_ff}
                         - {{(lpkf_pkg::INNOV_W-lpkf_pkg::STEP_W){
                              step_ff[lpkf_pkg::STEP_W-1]}}, step_ff};
               state_ff <= ST_GAIN_WAIT;
            end
            ST_GAIN_WAIT: begin
               if (div_status.ready) begin
                  state_ff <= ST_MUL_INNOV_LO;
               end
            end
            ST_MUL_INNOV_LO: begin
               state_ff <= ST_MUL_INNOV_HI;
            end
            ST_MUL_INNOV_HI: begin
               rl_ff    <= term;
               state_ff <= ST_CORR;
            end
            ST_CORR: begin
               // The upper innovation bits carry weight 2^32, which is a
               // multiple of the rounding unit, so their product adds shifted.
               corr_ff  <= {prod[lpkf_pkg::ACC_W-3:0], 2'b00}
                         + {{(lpkf_pkg::ACC_W-lpkf_pkg::TERM_W){1'b0}}, rl_ff};
               state_ff <= ST_EST;
            end
            ST_EST: begin
               est_new_ff <= lpkf_pkg::sat_sample(est_sum);
               cov_rnd_ff <= term[lpkf_pkg::COV_W:0];
               state_ff   <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (slot_free) begin
                  est_ff          <= est_new_ff;
                  cov_ff          <= cov_next;
                  lp2_ff          <= lp1_ff;
                  lp1_ff          <= lp_ff;
                  rsp_estimate_ff <= est_new_ff;
                  rsp_lowpass_ff  <= lp_ff;
                  rsp_valid_ff    <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_estimate      = rsp_estimate_ff;
   assign rsp_lowpass_value = rsp_lowpass_ff;

   // An accepted sample starts both the multiply sequence and the divider.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_MUL_IN && div_status.busy))
      else $error("accepted sample did not start the sequence and divider");

   // The correction multiply must only run on a finished gain.
   a_gain_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_INNOV_LO) |-> div_status.ready)
      else $error("correction multiply started before the gain was ready");

   // The gain never exceeds 1.0, so 1 - gain stays non-negative.
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      div_status.ready |-> (gain <= lpkf_pkg::GAIN_ONE))
      else $error("gain above 1.0");

   // A commit with a free result register hands out the result and idles.
   a_commit_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && slot_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("commit did not deliver a result");

   // Covariance only changes at a commit or a configuration write.
   a_cov_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_COMMIT && !csr_write) |=> $stable(cov_ff))
      else $error("covariance changed outside a commit");

endmodule
